// ===== design/second_order_iir_line_filter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the second-order IIR line filter
// Shared concurrent assertion forms, clocked on clk; IIRF_ASSERT is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SECOND_ORDER_IIR_LINE_FILTER_UNIT_ASSERT_SVH
`define SECOND_ORDER_IIR_LINE_FILTER_UNIT_ASSERT_SVH

// Checked only while out of reset
`define IIRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define IIRF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/iirf_pkg.sv =====
// ----------------------------------------------------------------------------
// iirf_pkg
// Types and constants shared by the second-order IIR line filter modules.
// ----------------------------------------------------------------------------
package iirf_pkg;

	// Fraction bits of samples and coefficients
	localparam int FRAC_BITS = 16;

	// Coefficient register file
	localparam int NUM_COEFS = 5;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_idx_t;

	// Control from the pipeline to the history registers
	typedef struct packed {
		logic advance;     // a word leaves stage 1 this cycle
		logic line_start;  // the word in stage 1 starts a new line
	} hist_ctl_t;

endpackage

// ===== design/iirf_coef_regs.sv =====
// ----------------------------------------------------------------------------
// iirf_coef_regs
// Five filter coefficient registers written through the configuration port.
// ----------------------------------------------------------------------------
module iirf_coef_regs #(
	parameter int COEF_WIDTH = 18
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [iirf_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [COEF_WIDTH-1:0]                 wr_data,
	output logic signed [COEF_WIDTH-1:0]          coefs [iirf_pkg::NUM_COEFS]
);
	import iirf_pkg::*;

	// 1.0 in the coefficient format
	localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(2 ** FRAC_BITS);

	logic signed [COEF_WIDTH-1:0] coef_q [NUM_COEFS];

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[COEF_B0] <= COEF_ONE;
			coef_q[COEF_B1] <= '0;
			coef_q[COEF_B2] <= '0;
			coef_q[COEF_A1] <= '0;
			coef_q[COEF_A2] <= '0;
		end else if (wr_en) begin
			case (wr_index)
				COEF_B0: coef_q[COEF_B0] <= wr_data;
				COEF_B1: coef_q[COEF_B1] <= wr_data;
				COEF_B2: coef_q[COEF_B2] <= wr_data;
				COEF_A1: coef_q[COEF_A1] <= wr_data;
				COEF_A2: coef_q[COEF_A2] <= wr_data;
				default: ;
			endcase
		end
	end

	assign coefs = coef_q;

endmodule

// ===== design/iirf_history.sv =====
// ----------------------------------------------------------------------------
// iirf_history
// Two input and two output history registers, read as zero at a line start.
// ----------------------------------------------------------------------------
module iirf_history #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iirf_pkg::hist_ctl_t           ctl,
	input  logic signed [DATA_WIDTH-1:0]  sample,
	input  logic signed [DATA_WIDTH-1:0]  y_new,
	output logic signed [DATA_WIDTH-1:0]  x1,
	output logic signed [DATA_WIDTH-1:0]  x2,
	output logic signed [DATA_WIDTH-1:0]  y1,
	output logic signed [DATA_WIDTH-1:0]  y2
);
	import iirf_pkg::*;

	logic signed [DATA_WIDTH-1:0] x1_q, x2_q, y1_q, y2_q;

	// Operands seen by the current word; a line start reads all zeros
	always_comb begin
		if (ctl.line_start) begin
			x1 = '0;
			x2 = '0;
			y1 = '0;
			y2 = '0;
		end else begin
			x1 = x1_q;
			x2 = x2_q;
			y1 = y1_q;
			y2 = y2_q;
		end
	end

	// Shift history when a word is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (ctl.advance) begin
			x2_q <= x1;
			x1_q <= sample;
			y2_q <= y1;
			y1_q <= y_new;
		end
	end

endmodule

// ===== design/iirf_mac.sv =====
// ----------------------------------------------------------------------------
// iirf_mac
// Five-term multiply-accumulate with rounding, saturation and addend.
// ----------------------------------------------------------------------------
module iirf_mac #(
	parameter int DATA_WIDTH = 32,
	parameter int COEF_WIDTH = 18
) (
	input  logic signed [COEF_WIDTH-1:0]  coefs [iirf_pkg::NUM_COEFS],
	input  logic signed [DATA_WIDTH-1:0]  sample,
	input  logic signed [DATA_WIDTH-1:0]  x1,
	input  logic signed [DATA_WIDTH-1:0]  x2,
	input  logic signed [DATA_WIDTH-1:0]  y1,
	input  logic signed [DATA_WIDTH-1:0]  y2,
	input  logic signed [DATA_WIDTH-1:0]  addend,
	output logic signed [DATA_WIDTH-1:0]  y,
	output logic signed [DATA_WIDTH-1:0]  result
);
	import iirf_pkg::*;

	localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;
	// Wide enough for five products and for a full saturation check
	localparam int ACC_W  = (PROD_W + 3 > DATA_WIDTH + FRAC_BITS + 1) ?
	                        PROD_W + 3 : DATA_WIDTH + FRAC_BITS + 1;
	localparam int SH_W   = ACC_W - FRAC_BITS;
	localparam int TOP_W  = SH_W - DATA_WIDTH + 1;

	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [PROD_W-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    acc_rnd;
	logic signed [SH_W-1:0]     acc_sh;
	logic        [TOP_W-1:0]    top_bits;
	logic signed [DATA_WIDTH:0] sum;

	// Products and their sum, exact with 2*FRAC_BITS fraction bits
	always_comb begin
		p_b0 = coefs[COEF_B0] * sample;
		p_b1 = coefs[COEF_B1] * x1;
		p_b2 = coefs[COEF_B2] * x2;
		p_a1 = coefs[COEF_A1] * y1;
		p_a2 = coefs[COEF_A2] * y2;
		acc  = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2);
	end

	// Round half up, drop the extra fraction, saturate to data width
	always_comb begin
		acc_rnd  = acc + HALF_LSB;
		acc_sh   = acc_rnd[ACC_W-1:FRAC_BITS];
		top_bits = acc_sh[SH_W-1:DATA_WIDTH-1];
		if ((&top_bits) || !(|top_bits)) begin
			y = acc_sh[DATA_WIDTH-1:0];
		end else if (acc_sh[SH_W-1]) begin
			y = DATA_MIN;
		end else begin
			y = DATA_MAX;
		end
	end

	// Filter output plus addend, saturated again
	always_comb begin
		sum = (DATA_WIDTH+1)'(y) + (DATA_WIDTH+1)'(addend);
		if (sum[DATA_WIDTH] == sum[DATA_WIDTH-1]) begin
			result = sum[DATA_WIDTH-1:0];
		end else if (sum[DATA_WIDTH]) begin
			result = DATA_MIN;
		end else begin
			result = DATA_MAX;
		end
	end

endmodule

// ===== design/second_order_iir_line_filter_unit.sv =====
// ----------------------------------------------------------------------------
// second_order_iir_line_filter_unit
// Streaming second-order recursive filter with per-line history clear.
//
//   Channel  Dir  Handshake          Content
//   s_*      in   tvalid/tready      sample, addend; tuser line_start, warm_up
//   m_*      out  tvalid/tready      filtered_value
//   wr_*     in   wr_en              coefficient index and value
//
// One word per cycle sustained while the output is not stalled. A word is
// registered in stage 1 at acceptance, goes through the multiply-accumulate
// there and is registered into the output register that drives m_tdata. The
// feedback path through the history registers sets the one-word-per-cycle
// figure. A warm-up word only advances the history. With the output stalled,
// one more word is taken into stage 1 and then s_tready drops. Reset clears
// coefficients to the pass filter (b0 = 1.0), history and valid flags.
// ----------------------------------------------------------------------------
module second_order_iir_line_filter_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int COEF_WIDTH = 18,
	localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_TDATA_W-1:0]              s_tdata,   // sample, addend
	input  logic [1:0]                         s_tuser,   // line_start, warm_up
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_TDATA_W-1:0]             m_tdata,   // filtered_value
	// configuration
	input  logic                               wr_en,
	input  logic [iirf_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [COEF_WIDTH-1:0]              wr_data
);
	import iirf_pkg::*;

	logic signed [COEF_WIDTH-1:0] coefs [NUM_COEFS];

	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] sample_s1, addend_s1;
	logic                         line_start_s1, warm_up_s1;

	logic signed [DATA_WIDTH-1:0] x1, x2, y1, y2, y_new, result;
	hist_ctl_t                    hist_ctl;

	logic                         out_valid_q;
	logic [DATA_WIDTH-1:0]        out_data_q;

	logic                         out_free, advance;

	// Coefficients
	iirf_coef_regs #(.COEF_WIDTH(COEF_WIDTH)) u_coef_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coefs    (coefs)
	);

	// Flow control: a warm-up word never waits on the output
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (warm_up_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	// Stage 1 input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1     <= s_tdata[DATA_WIDTH-1:0];
			addend_s1     <= s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
			line_start_s1 <= s_tuser[0];
			warm_up_s1    <= s_tuser[1];
		end
	end

	// History
	assign hist_ctl.advance    = advance;
	assign hist_ctl.line_start = line_start_s1;

	iirf_history #(.DATA_WIDTH(DATA_WIDTH)) u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hist_ctl),
		.sample (sample_s1),
		.y_new  (y_new),
		.x1     (x1),
		.x2     (x2),
		.y1     (y1),
		.y2     (y2)
	);

	// Filter arithmetic
	iirf_mac #(.DATA_WIDTH(DATA_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_mac (
		.coefs  (coefs),
		.sample (sample_s1),
		.x1     (x1),
		.x2     (x2),
		.y1     (y1),
		.y2     (y2),
		.addend (addend_s1),
		.y      (y_new),
		.result (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && !warm_up_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && !warm_up_s1) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_data_q);

endmodule

// ===== design/iirf_checker.sv =====
// ----------------------------------------------------------------------------
// iirf_checker
// Port-level checks on the IIR line filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "second_order_iir_line_filter_unit_assert.svh"

module iirf_checker #(
	parameter int DATA_WIDTH = 32,
	localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [1:0]             s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result word keeps its valid
	`IIRF_ASSERT(a_out_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

	// A stalled result word keeps its data
	`IIRF_ASSERT(a_out_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed while stalled")

	// A fresh result comes from an accepted non-warm-up input word
	`IIRF_ASSERT(a_out_source, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && !s_tuser[1], 2), "result without a matching input word")

	// Nothing is offered on the first edge after reset release
	`IIRF_ASSERT_ALWAYS(a_reset_quiet, $rose(arst_n) |-> !m_tvalid, "result valid right after reset")

endmodule

bind second_order_iir_line_filter_unit iirf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_iirf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
